// ===== design/mgst_pkg.sv =====
`default_nettype none

package mgst_pkg;

  localparam int NUM_GATES  = 20;
  localparam int TIME_WIDTH = 32;

  localparam int SENSE_W   = 20;
  localparam int STAMP_W   = 32;
  localparam int IDX_W     = 5;
  localparam int SPEED_W   = 20;
  localparam int SPACING_W = 16;
  localparam int GATE_W    = $clog2(NUM_GATES);

  // mm/ms -> 0.01 km/h
  localparam int KMH_FACTOR = 3600 * 100 / 1000;
  localparam int FACTOR_W   = $clog2(KMH_FACTOR + 1);
  localparam int NUM_W      = SPACING_W + FACTOR_W;
  localparam int DIV_CNT_W  = $clog2(NUM_W);

  localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(1000);
  localparam logic [SPEED_W-1:0]   SPEED_MAX     = '1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_WAITING = 2'd0,
    KIND_ARMED   = 2'd1,
    KIND_REPORT  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [IDX_W-1:0]      idx;
    logic                  valid;
    logic [TIME_WIDTH-1:0] dt;
    logic                  last;
  } job_t;

endpackage

`default_nettype wire

// ===== design/mgst_front.sv =====
`default_nettype none

module mgst_front import mgst_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               sample_valid,
  output logic                    sample_stall,
  input  wire logic [SENSE_W-1:0] sensor_levels,
  input  wire logic [STAMP_W-1:0] time_ms,
  output logic                    job_push,
  output job_t                    job,
  input  wire logic               job_full
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_WALK = 2'b10
  } fstate_t;

  fstate_t               state;
  logic [NUM_GATES-1:0]  latched;
  logic [TIME_WIDTH-1:0] stamp [NUM_GATES];
  logic [GATE_W-1:0]     cnt;

  logic [NUM_GATES-1:0]  gate_low;
  logic [NUM_GATES-1:0]  latched_next;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] diff_ab;
  logic [TIME_WIDTH-1:0] diff_ba;
  logic                  accept;
  logic                  report;
  logic                  walk_step;
  logic                  walk_last;

  assign gate_low     = ~NUM_GATES'(sensor_levels);
  assign now          = TIME_WIDTH'(time_ms);
  assign sample_stall = !(state == F_IDLE && !job_full);
  assign accept       = sample_valid && !sample_stall;
  assign latched_next = latched | gate_low;
  assign report       = latched_next[0] & latched_next[1];
  assign walk_step    = (state == F_WALK) && !job_full;
  assign walk_last    = (cnt == GATE_W'(NUM_GATES - 1));
  assign diff_ab      = stamp[0] - stamp[1];
  assign diff_ba      = stamp[1] - stamp[0];

  // pair under test always sits at positions 0 and 1; the ring rotates each step
  always_comb begin
    job = '0;
    if (state == F_WALK) begin
      job.kind  = KIND_REPORT;
      job.idx   = IDX_W'(cnt);
      job.valid = latched[0] & latched[1];
      job.dt    = (stamp[0] > stamp[1]) ? diff_ab : diff_ba;
      job.last  = walk_last;
    end else begin
      job.kind  = (|latched_next) ? KIND_ARMED : KIND_WAITING;
      job.last  = 1'b1;
    end
  end

  assign job_push = (accept && !report) || walk_step;

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NUM_GATES; i++) begin
        if (gate_low[i] && !latched[i]) begin
          stamp[i] <= now;
        end
      end
    end else if (walk_step) begin
      for (int i = 0; i < NUM_GATES; i++) begin
        stamp[i] <= stamp[(i + 1) % NUM_GATES];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      latched <= '0;
      cnt     <= '0;
    end else if (accept) begin
      latched <= latched_next;
      cnt     <= '0;
      if (report) begin
        state <= F_WALK;
      end
    end else if (walk_step) begin
      cnt <= cnt + 1'b1;
      if (walk_last) begin
        latched <= '0;
        state   <= F_IDLE;
      end else begin
        latched <= {latched[0], latched[NUM_GATES-1:1]};
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/mgst_queue.sv =====
`default_nettype none

module mgst_queue import mgst_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      head,
  output logic      empty
);

  job_t              slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/mgst_back.sv =====
`default_nettype none

module mgst_back import mgst_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 spacing_valid,
  input  wire logic [SPACING_W-1:0] gate_spacing_mm,
  input  wire job_t                 job,
  input  wire logic                 job_empty,
  output logic                      job_pop,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic [1:0]                result_kind,
  output logic [IDX_W-1:0]          pair_index,
  output logic [SPEED_W-1:0]        speed_centi_kmh,
  output logic                      speed_valid,
  output logic                      overflow,
  output logic                      last
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_DONE = 3'b100
  } bstate_t;

  bstate_t               state;
  logic [SPACING_W-1:0]  spacing;
  logic [TIME_WIDTH-1:0] rem;
  logic [TIME_WIDTH-1:0] divisor;
  logic [NUM_W-1:0]      quo;
  logic [DIV_CNT_W-1:0]  dcnt;
  logic [IDX_W-1:0]      hold_idx;
  logic                  hold_last;

  logic                  out_free;
  logic                  need_div;
  logic                  load_direct;
  logic                  load_div;
  logic                  load_done;
  logic [TIME_WIDTH+1:0] trial;
  logic                  ge;
  logic                  sat;

  assign out_free    = !result_valid || !result_stall;
  assign need_div    = (job.kind == KIND_REPORT) && job.valid && (job.dt != '0);
  assign load_div    = (state == B_IDLE) && !job_empty && need_div;
  assign load_direct = (state == B_IDLE) && !job_empty && !need_div && out_free;
  assign load_done   = (state == B_DONE) && out_free;
  assign job_pop     = load_div || load_direct;

  // restoring divide, one quotient bit per cycle
  assign trial = {1'b0, rem, quo[NUM_W-1]} - {2'b00, divisor};
  assign ge    = !trial[TIME_WIDTH+1];
  assign sat   = |quo[NUM_W-1:SPEED_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= SPACING_RESET;
    end else if (spacing_valid) begin
      spacing <= gate_spacing_mm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      dcnt  <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (load_div) begin
            state <= B_DIV;
            dcnt  <= DIV_CNT_W'(NUM_W - 1);
          end
        end
        B_DIV: begin
          dcnt <= dcnt - 1'b1;
          if (dcnt == '0) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_div) begin
      quo       <= NUM_W'(spacing) * NUM_W'(KMH_FACTOR);
      rem       <= '0;
      divisor   <= job.dt;
      hold_idx  <= job.idx;
      hold_last <= job.last;
    end else if (state == B_DIV) begin
      quo <= {quo[NUM_W-2:0], ge};
      rem <= ge ? trial[TIME_WIDTH-1:0] : {rem[TIME_WIDTH-2:0], quo[NUM_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_direct || load_done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // a report that skips the divider is either an open pair or zero dt
  always_ff @(posedge clk) begin
    if (load_direct) begin
      result_kind     <= job.kind;
      pair_index      <= job.idx;
      speed_centi_kmh <= job.valid ? SPEED_MAX : '0;
      speed_valid     <= job.valid;
      overflow        <= job.valid;
      last            <= job.last;
    end else if (load_done) begin
      result_kind     <= KIND_REPORT;
      pair_index      <= hold_idx;
      speed_centi_kmh <= sat ? SPEED_MAX : quo[SPEED_W-1:0];
      speed_valid     <= 1'b1;
      overflow        <= sat;
      last            <= hold_last;
    end
  end

endmodule

`default_nettype wire

// ===== design/multi_gate_speed_trap.sv =====
// A status result passes through the job queue and is registered at the output.
// A report sample gives NUM_GATES results; each complete pair with nonzero dt
// runs NUM_W (25) divider steps, one result at a time, the divider being
// the bottleneck. The next sample is taken once the pair walk ends, which
// queue backpressure can delay. Reset (rst, synchronous) clears latch flags,
// queue and output valid, and sets gate spacing to 1000 mm.
`default_nettype none

module multi_gate_speed_trap import mgst_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 sample_valid,
  output logic                      sample_stall,
  input  wire logic [SENSE_W-1:0]   sensor_levels,
  input  wire logic [STAMP_W-1:0]   time_ms,
  input  wire logic                 spacing_valid,
  output logic                      spacing_ready,
  input  wire logic [SPACING_W-1:0] gate_spacing_mm,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic [1:0]                result_kind,
  output logic [IDX_W-1:0]          pair_index,
  output logic [SPEED_W-1:0]        speed_centi_kmh,
  output logic                      speed_valid,
  output logic                      overflow,
  output logic                      last
);

  job_t push_job;
  job_t head_job;
  logic job_push;
  logic job_full;
  logic job_pop;
  logic job_empty;
  logic spacing_we;

  assign spacing_ready = 1'b1;
  assign spacing_we    = spacing_valid && spacing_ready;

  mgst_front u_front (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .sensor_levels (sensor_levels),
    .time_ms       (time_ms),
    .job_push      (job_push),
    .job           (push_job),
    .job_full      (job_full)
  );

  mgst_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (push_job),
    .full     (job_full),
    .pop      (job_pop),
    .head     (head_job),
    .empty    (job_empty)
  );

  mgst_back u_back (
    .clk             (clk),
    .rst             (rst),
    .spacing_valid   (spacing_we),
    .gate_spacing_mm (gate_spacing_mm),
    .job             (head_job),
    .job_empty       (job_empty),
    .job_pop         (job_pop),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result_kind     (result_kind),
    .pair_index      (pair_index),
    .speed_centi_kmh (speed_centi_kmh),
    .speed_valid     (speed_valid),
    .overflow        (overflow),
    .last            (last)
  );

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind != KIND_REPORT) |-> last)
    else $error("status result without last");

  a_open_pair: assert property (@(posedge clk) disable iff (rst)
    result_valid && !speed_valid |-> (speed_centi_kmh == '0) && !overflow)
    else $error("open pair carries speed or overflow");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid && overflow |-> (speed_centi_kmh == SPEED_MAX))
    else $error("overflow without saturated speed");

  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind == KIND_REPORT) && last
      |-> (pair_index == IDX_W'(NUM_GATES - 1)))
    else $error("report ended on wrong pair");

endmodule

`default_nettype wire
